// ===== hdl/cbd_pkg.sv =====
package cbd_pkg;

    localparam int SIZE_BITS_DEF = 32;
    localparam int COUNT_BITS    = 32;
    localparam int BYTE_BITS     = 8;
    localparam int KIND_BITS     = 2;

    localparam logic [BYTE_BITS-1:0] CH_CR   = 8'h0D;
    localparam logic [BYTE_BITS-1:0] CH_LF   = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CH_SEMI = 8'h3B;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [10:0] {
        PH_SIZE    = 11'b000_0000_0001,
        PH_SIZE_CR = 11'b000_0000_0010,
        PH_EXT     = 11'b000_0000_0100,
        PH_EXT_CR  = 11'b000_0000_1000,
        PH_DATA    = 11'b000_0001_0000,
        PH_GAP1    = 11'b000_0010_0000,
        PH_GAP2    = 11'b000_0100_0000,
        PH_TRL1    = 11'b000_1000_0000,
        PH_TRL2    = 11'b001_0000_0000,
        PH_DONE    = 11'b010_0000_0000,
        PH_ERR     = 11'b100_0000_0000
    } phase_t;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_DATA = 2'd0,
        KIND_DONE = 2'd1,
        KIND_BAD  = 2'd2,
        KIND_OVF  = 2'd3
    } kind_t;

    typedef struct packed {
        phase_t                phase;
        logic [COUNT_BITS-1:0] count;
    } ctl_t;

    typedef struct packed {
        logic                  valid;
        kind_t                 kind;
        logic [BYTE_BITS-1:0]  data;
        logic [COUNT_BITS-1:0] length;
    } res_t;

endpackage

// ===== hdl/cbd_step.sv =====
module cbd_step #(
    parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
    input  logic [cbd_pkg::BYTE_BITS-1:0] in_byte,
    input  logic                          new_body,
    input  cbd_pkg::ctl_t                 ctl_cur,
    input  logic [SIZE_BITS-1:0]          chunk_cur,
    output cbd_pkg::ctl_t                 ctl_next,
    output logic [SIZE_BITS-1:0]          chunk_next,
    output cbd_pkg::res_t                 res
);

    cbd_pkg::ctl_t        ctl_base;
    logic [SIZE_BITS-1:0] chunk_base;
    logic [SIZE_BITS-1:0] chunk_dec;
    logic                 is_num;
    logic                 is_alpha;
    logic [3:0]           digit;

    always_comb begin
        is_num   = in_byte inside {[8'h30:8'h39]};
        is_alpha = in_byte inside {[8'h41:8'h46], [8'h61:8'h66]};
        digit    = is_num ? in_byte[3:0] : 4'(in_byte[3:0] + 4'd9);
    end

    always_comb begin
        ctl_base   = ctl_cur;
        chunk_base = chunk_cur;
        if (new_body) begin
            ctl_base.phase = cbd_pkg::PH_SIZE;
            ctl_base.count = '0;
            chunk_base     = '0;
        end
        chunk_dec = chunk_base - SIZE_BITS'(1);

        ctl_next   = ctl_base;
        chunk_next = chunk_base;
        res.valid  = 1'b0;
        res.kind   = cbd_pkg::KIND_DATA;
        res.data   = '0;

        case (ctl_base.phase)
            cbd_pkg::PH_SIZE: begin
                if (in_byte == cbd_pkg::CH_CR) begin
                    ctl_next.phase = cbd_pkg::PH_SIZE_CR;
                end else if (in_byte == cbd_pkg::CH_SEMI) begin
                    ctl_next.phase = cbd_pkg::PH_EXT;
                end else if (!(is_num || is_alpha)) begin
                    ctl_next.phase = cbd_pkg::PH_ERR;
                    res.valid      = 1'b1;
                    res.kind       = cbd_pkg::KIND_BAD;
                end else if (chunk_base[SIZE_BITS-1 -: 4] != 4'd0) begin
                    ctl_next.phase = cbd_pkg::PH_ERR;
                    res.valid      = 1'b1;
                    res.kind       = cbd_pkg::KIND_OVF;
                end else begin
                    chunk_next = {chunk_base[SIZE_BITS-5:0], digit};
                end
            end
            cbd_pkg::PH_SIZE_CR: begin
                if (in_byte == cbd_pkg::CH_LF) begin
                    ctl_next.phase = (chunk_base == '0) ? cbd_pkg::PH_TRL1
                                                        : cbd_pkg::PH_DATA;
                end else begin
                    ctl_next.phase = cbd_pkg::PH_ERR;
                    res.valid      = 1'b1;
                    res.kind       = cbd_pkg::KIND_BAD;
                end
            end
            cbd_pkg::PH_EXT: begin
                if (in_byte == cbd_pkg::CH_CR) begin
                    ctl_next.phase = cbd_pkg::PH_EXT_CR;
                end
            end
            cbd_pkg::PH_EXT_CR: begin
                if (in_byte == cbd_pkg::CH_LF) begin
                    ctl_next.phase = (chunk_base == '0) ? cbd_pkg::PH_TRL1
                                                        : cbd_pkg::PH_DATA;
                end else if (in_byte != cbd_pkg::CH_CR) begin
                    ctl_next.phase = cbd_pkg::PH_EXT;
                end
            end
            cbd_pkg::PH_DATA: begin
                if (ctl_base.count != cbd_pkg::COUNT_MAX) begin
                    ctl_next.count = ctl_base.count + cbd_pkg::COUNT_BITS'(1);
                end
                chunk_next = chunk_dec;
                if (chunk_dec == '0) begin
                    ctl_next.phase = cbd_pkg::PH_GAP1;
                end
                res.valid = 1'b1;
                res.kind  = cbd_pkg::KIND_DATA;
                res.data  = in_byte;
            end
            cbd_pkg::PH_GAP1: begin
                ctl_next.phase = cbd_pkg::PH_GAP2;
            end
            cbd_pkg::PH_GAP2: begin
                ctl_next.phase = cbd_pkg::PH_SIZE;
                chunk_next     = '0;
            end
            cbd_pkg::PH_TRL1: begin
                ctl_next.phase = cbd_pkg::PH_TRL2;
            end
            cbd_pkg::PH_TRL2: begin
                ctl_next.phase = cbd_pkg::PH_DONE;
                res.valid      = 1'b1;
                res.kind       = cbd_pkg::KIND_DONE;
            end
            default: begin
            end
        endcase

        res.length = ctl_next.count;
    end

endmodule

// ===== hdl/chunked_body_decoder.sv =====
// Decodes a body in chunked transfer coding, one byte per beat. Set s_tuser on the first
// byte of each body; before the first such beat the block acts as if a body began at reset.
// Each payload byte leaves as a beat of kind 0; the end of the body (kind 1), a bad size
// character (kind 2) or a size wider than SIZE_BITS (kind 3) leaves one beat and the block
// then drops bytes until the next start. Size lines, extensions, CR LF and the two bytes
// after each chunk give no beat. m_tdata carries the payload byte in bits 7:0 and the
// saturating payload count of the body in bits 39:8. Throughput is one byte per cycle
// while m_tready keeps up with results; a byte waits in the input register while the
// parse logic updates the phase and counters, and its result goes to an output register.
module chunked_body_decoder #(
    parameter int SIZE_BITS = cbd_pkg::SIZE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // in_byte
    input  logic        s_tuser,   // new_body
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // out_byte [7:0], body_length [39:8]
    output logic [1:0]  m_tuser    // out_kind
);

    logic                                 in_valid_reg;
    logic [cbd_pkg::BYTE_BITS-1:0]        in_byte_reg;
    logic                                 in_start_reg;
    cbd_pkg::ctl_t                        ctl_reg;
    cbd_pkg::ctl_t                        ctl_next;
    logic [SIZE_BITS-1:0]                 chunk_reg;
    logic [SIZE_BITS-1:0]                 chunk_next;
    cbd_pkg::res_t                        res;
    logic                                 out_valid_reg;
    cbd_pkg::kind_t                       out_kind_reg;
    logic [cbd_pkg::BYTE_BITS-1:0]        out_byte_reg;
    logic [cbd_pkg::COUNT_BITS-1:0]       out_len_reg;
    logic                                 advance;

    cbd_step #(
        .SIZE_BITS(SIZE_BITS)
    ) u_step (
        .in_byte    (in_byte_reg),
        .new_body   (in_start_reg),
        .ctl_cur    (ctl_reg),
        .chunk_cur  (chunk_reg),
        .ctl_next   (ctl_next),
        .chunk_next (chunk_next),
        .res        (res)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready || !res.valid);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg.phase <= cbd_pkg::PH_SIZE;
            ctl_reg.count <= '0;
            chunk_reg     <= '0;
        end else if (advance) begin
            ctl_reg   <= ctl_next;
            chunk_reg <= chunk_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance && res.valid) begin
                out_valid_reg <= 1'b1;
            end
        end
        if (advance && res.valid) begin
            out_kind_reg <= res.kind;
            out_byte_reg <= res.data;
            out_len_reg  <= res.length;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_len_reg, out_byte_reg};
    assign m_tuser  = out_kind_reg;

    a_data_left: assert property (@(posedge aclk) disable iff (!aresetn)
        ctl_reg.phase == cbd_pkg::PH_DATA |-> chunk_reg != '0)
        else $error("payload phase with no bytes left");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg))
        else $error("stalled byte lost");

    a_count_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !in_start_reg |=> ctl_reg.count >= $past(ctl_reg.count))
        else $error("payload count went down");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_len_reg))
        else $error("pending result overwritten");

    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_kind_reg != cbd_pkg::KIND_DATA |-> out_byte_reg == '0)
        else $error("status beat carries a byte");

endmodule
